// ----- hw/rtl/radix_number_token_parser_top_defines.svh -----
// Assertion macros for the radix number token parser.
`ifndef RADIX_NUMBER_TOKEN_PARSER_TOP_DEFINES_SVH
`define RADIX_NUMBER_TOKEN_PARSER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define RNTP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define RNTP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RNTP_ASSERT_SAME(lbl, ante, cons, msg)
`define RNTP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/rntp_pkg.sv -----
package rntp_pkg;

	localparam int ADDR_W = 1;
	localparam int DATA_W = 32;
	localparam int OUT_W  = 32;

	localparam logic [ADDR_W-1:0] REG_DEFAULT_BASE = 1'b0;

	localparam logic [5:0] BASE_RESET = 6'd10;
	localparam logic [5:0] BASE_DEC   = 6'd10;
	localparam logic [5:0] BASE_HEX   = 6'd16;
	localparam logic [5:0] BASE_BIN   = 6'd2;

	localparam logic [7:0] CHAR_HASH   = 8'h23;
	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_PCT    = 8'h25;
	localparam logic [7:0] CHAR_APOS   = 8'h27;
	localparam logic [7:0] CHAR_MINUS  = 8'h2D;
	localparam logic [7:0] CHAR_0      = 8'h30;
	localparam logic [7:0] CHAR_9      = 8'h39;
	localparam logic [7:0] CHAR_UA     = 8'h41;
	localparam logic [7:0] CHAR_UF     = 8'h46;
	localparam logic [7:0] CHAR_LA     = 8'h61;
	localparam logic [7:0] CHAR_LF     = 8'h66;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} digit_t;

	function automatic digit_t digit_of(logic [7:0] c, logic [5:0] base);
		digit_t d;
		d.ok  = 1'b0;
		d.val = 4'd0;
		if (c inside {[CHAR_0:CHAR_9]} &&
				(base >= BASE_DEC || 8'(c - CHAR_0) < 8'(base))) begin
			d.ok  = 1'b1;
			d.val = 4'(c - CHAR_0);
		end else if (base == BASE_HEX && c inside {[CHAR_UA:CHAR_UF]}) begin
			d.ok  = 1'b1;
			d.val = 4'(c - CHAR_UA + 8'd10);
		end else if (base == BASE_HEX && c inside {[CHAR_LA:CHAR_LF]}) begin
			d.ok  = 1'b1;
			d.val = 4'(c - CHAR_LA + 8'd10);
		end
		return d;
	endfunction

endpackage

// ----- hw/rtl/radix_number_token_parser_top.sv -----
// Radix number token parser.
// Input stream (s_*): one token character per transfer in s_tdata[7:0],
// s_tlast set on the final character of the token. Output stream (m_*):
// one transfer per token, m_tuser = is_number, m_tdata = value (zero when
// not a number). APB port: register 0 (byte address 0) is default_base,
// 6 bits, reset 10; it is sampled on the first character of each token.
// Throughput: one character per cycle while the skid entry is empty. The
// per-character multiply-add closes a loop on the accumulator.
// The result for a token is registered into the result register, or into
// the skid entry when the result register still holds an untaken result.
// Output side has a result register plus one skid entry; s_tready drops
// only when both hold results the receiver has not taken, so characters
// keep flowing while only the result register is stalled.
// Reset: all token state clears, default_base returns to 10, both output
// entries are emptied.
`include "radix_number_token_parser_top_defines.svh"

module radix_number_token_parser_top #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,  // [7:0] token_char
	input  logic                          s_tlast,  // is_last
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [rntp_pkg::OUT_W-1:0]    m_tdata,  // [31:0] number_value
	output logic                          m_tuser,  // is_number
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rntp_pkg::ADDR_W-1:0]   paddr,
	input  logic [rntp_pkg::DATA_W-1:0]   pwdata,
	output logic [rntp_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int OW   = rntp_pkg::OUT_W;
	localparam int ExtW = VALUE_WIDTH + OW;
	localparam int PW   = VALUE_WIDTH + 6;

	localparam logic [2:0] ST_NONE = 3'd0;
	localparam logic [2:0] ST_HASH = 3'd1;
	localparam logic [2:0] ST_DOL  = 3'd2;
	localparam logic [2:0] ST_PCT  = 3'd3;
	localparam logic [2:0] ST_BODY = 3'd4;

	logic [5:0]             dflt_base_q;
	logic [2:0]             pos_q;
	logic [2:0]             stage_q;
	logic [5:0]             base_q;
	logic                   neg_q;
	logic [VALUE_WIDTH-1:0] acc_q;
	logic                   seen_q;
	logic                   err_q;
	logic [7:0]             qchar_q;
	logic                   qok_q;

	logic                   out_valid_q;
	logic                   out_num_q;
	logic [OW-1:0]          out_val_q;
	logic                   skid_valid_q;
	logic                   skid_num_q;
	logic [OW-1:0]          skid_val_q;

	logic                   s_fire;
	logic                   m_fire;
	logic [7:0]             c;
	logic [5:0]             cur_base;
	logic [2:0]             stage_n;
	logic [5:0]             base_n;
	logic                   neg_n;
	logic [VALUE_WIDTH-1:0] acc_n;
	logic                   seen_n;
	logic                   err_n;
	logic                   qok_n;
	logic [PW-1:0]          prod;
	rntp_pkg::digit_t       dig;
	logic [VALUE_WIDTH-1:0] signed_val;
	logic [ExtW-1:0]        val_ext;
	logic                   res_num;
	logic [OW-1:0]          res_val;

	// config port
	assign pready = 1'b1;
	assign prdata = rntp_pkg::DATA_W'(dflt_base_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_base_q <= rntp_pkg::BASE_RESET;
		end else if (psel && penable && pwrite && pready &&
				paddr == rntp_pkg::REG_DEFAULT_BASE) begin
			dflt_base_q <= pwdata[5:0];
		end
	end

	assign s_tready = !skid_valid_q;
	assign s_fire   = s_tvalid && s_tready;
	assign m_fire   = out_valid_q && m_tready;
	assign c        = s_tdata;
	assign cur_base = (pos_q == 3'd0) ? dflt_base_q : base_q;

	assign dig  = rntp_pkg::digit_of(c, cur_base);
	assign prod = PW'(acc_q) * PW'(cur_base);

	always_comb begin
		stage_n = stage_q;
		base_n  = cur_base;
		neg_n   = neg_q;
		acc_n   = acc_q;
		seen_n  = seen_q;
		err_n   = err_q;
		if (!err_q) begin
			if (stage_q < ST_HASH && c == rntp_pkg::CHAR_HASH) begin
				base_n  = rntp_pkg::BASE_DEC;
				stage_n = ST_HASH;
			end else if (stage_q < ST_DOL && c == rntp_pkg::CHAR_DOLLAR) begin
				base_n  = rntp_pkg::BASE_HEX;
				stage_n = ST_DOL;
			end else if (stage_q < ST_PCT && c == rntp_pkg::CHAR_PCT) begin
				base_n  = rntp_pkg::BASE_BIN;
				stage_n = ST_PCT;
			end else if (stage_q < ST_BODY && c == rntp_pkg::CHAR_MINUS &&
					cur_base == rntp_pkg::BASE_DEC) begin
				neg_n   = 1'b1;
				stage_n = ST_BODY;
			end else begin
				stage_n = ST_BODY;
				if (dig.ok) begin
					acc_n  = prod[VALUE_WIDTH-1:0] + VALUE_WIDTH'(dig.val);
					seen_n = 1'b1;
				end else begin
					err_n = 1'b1;
				end
			end
		end
	end

	always_comb begin
		case (pos_q)
			3'd0:    qok_n = (c == rntp_pkg::CHAR_APOS);
			3'd1:    qok_n = qok_q;
			3'd2:    qok_n = qok_q && (c == rntp_pkg::CHAR_APOS);
			default: qok_n = 1'b0;
		endcase
	end

	assign signed_val = neg_n ? (VALUE_WIDTH'(0) - acc_n) : acc_n;
	assign val_ext    = ExtW'(signed_val);

	always_comb begin
		res_num = 1'b0;
		res_val = '0;
		if (qok_n && pos_q == 3'd2) begin
			res_num = 1'b1;
			res_val = OW'(qchar_q);
		end else if (!err_n && seen_n) begin
			res_num = 1'b1;
			res_val = val_ext[OW-1:0];
		end
	end

	// token state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= 3'd0;
			stage_q <= ST_NONE;
			base_q  <= rntp_pkg::BASE_RESET;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			seen_q  <= 1'b0;
			err_q   <= 1'b0;
			qchar_q <= 8'd0;
			qok_q   <= 1'b0;
		end else if (s_fire) begin
			if (s_tlast) begin
				pos_q   <= 3'd0;
				stage_q <= ST_NONE;
				base_q  <= dflt_base_q;
				neg_q   <= 1'b0;
				acc_q   <= '0;
				seen_q  <= 1'b0;
				err_q   <= 1'b0;
				qchar_q <= 8'd0;
				qok_q   <= 1'b0;
			end else begin
				if (pos_q != 3'd7)
					pos_q <= pos_q + 3'd1;
				stage_q <= stage_n;
				base_q  <= base_n;
				neg_q   <= neg_n;
				acc_q   <= acc_n;
				seen_q  <= seen_n;
				err_q   <= err_n;
				qok_q   <= qok_n;
				if (pos_q == 3'd1)
					qchar_q <= c;
			end
		end
	end

	// result register and skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (m_fire) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (s_fire && s_tlast) begin
			if (!out_valid_q || m_fire)
				out_valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (m_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (m_fire) begin
				out_num_q <= skid_num_q;
				out_val_q <= skid_val_q;
			end
		end else if (s_fire && s_tlast) begin
			if (!out_valid_q || m_fire) begin
				out_num_q <= res_num;
				out_val_q <= res_val;
			end else begin
				skid_num_q <= res_num;
				skid_val_q <= res_val;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_num_q;
	assign m_tdata  = out_val_q;

	`RNTP_ASSERT_SAME(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full, output empty")
	`RNTP_ASSERT_NEXT(a_token_cleared, s_fire && s_tlast, pos_q == 3'd0 && stage_q == ST_NONE && !err_q && !seen_q, "token state not cleared")
	`RNTP_ASSERT_SAME(a_err_in_body, err_q || neg_q, stage_q == ST_BODY, "error or sign outside body")

endmodule
